// ===== rtl/srsw_pkg.sv =====
// Shared types and constants for the selective-repeat sender window.
`timescale 1ns / 1ps
`default_nettype none
package srsw_pkg;

  localparam int WindowSlots = 8;
  localparam int SlotIdxW    = (WindowSlots > 1) ? $clog2(WindowSlots) : 1;
  localparam int CntW        = $clog2(WindowSlots + 1);
  localparam int SeqW        = 16;
  localparam int TickW       = 20;

  localparam logic [TickW-1:0] TimeoutReset = TickW'(1000);
  localparam logic [TickW-1:0] IdleMax      = {TickW{1'b1}};

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ACK  = 2'd1,
    OP_SEND = 2'd2,
    OP_RSVD = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_NEW     = 2'd1,
    KIND_RETX    = 2'd2,
    KIND_REFUSED = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic exec;
    logic retx;
  } srsw_cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_start;
    logic scan_last;
  } srsw_sts_t;

endpackage
`default_nettype wire

// ===== rtl/srsw_in_if.sv =====
// Request channel: opcode, acknowledged sequence number and end-of-data flag.
`timescale 1ns / 1ps
`default_nettype none
interface srsw_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [srsw_pkg::SeqW-1:0] ack_seq;
  logic                      final_packet;

  modport source (output valid, output opcode, output ack_seq, output final_packet,
                  input ready);
  modport sink (input valid, input opcode, input ack_seq, input final_packet,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/srsw_out_if.sv =====
// Result channel: send, retransmit, refusal and status records.
`timescale 1ns / 1ps
`default_nettype none
interface srsw_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [srsw_pkg::SeqW-1:0] seq_out;
  logic                      packet_is_last;
  logic                      relay_select;
  logic [srsw_pkg::SeqW-1:0] window_base;
  logic                      transfer_done;
  logic                      run_end;

  modport source (output valid, output kind, output seq_out, output packet_is_last,
                  output relay_select, output window_base, output transfer_done,
                  output run_end, input ready);
  modport sink (input valid, input kind, input seq_out, input packet_is_last,
                input relay_select, input window_base, input transfer_done,
                input run_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/selective_repeat_sender_window_top.sv =====
// Top level of the selective-repeat sender window.
//
// Channels: req_i (sink) carries opcode, ack_seq and final_packet; rsp_o
// (source) carries one record per result, run_end marking the last record
// of a request. Both transfer on valid && ready. cfg_we_i / cfg_data_i write
// timeout_ticks with no wait; write it only while the block is idle.
// Every result is registered and shows in the cycle after the cycle that
// produces it. Acks, sends, refusals and plain ticks each give one record;
// a request is taken each cycle while results are drained as they appear.
// A timeout tick with k unacked slots first loads the pending-slot mask,
// then emits k retransmissions from the scan of the mask, one per cycle
// while the output register is free, before the next request is accepted.
// The output register frees in the cycle its record transfers; when the
// receiver stalls, the record holds and req_i.ready stays low.
// Reset: empty window, base and next sequence 0, more data pending, idle
// timer 0, timeout_ticks 1000. No memory clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module selective_repeat_sender_window_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [srsw_pkg::TickW-1:0] cfg_data_i,
  srsw_in_if.sink                         req_i,
  srsw_out_if.source                      rsp_o
);
  import srsw_pkg::*;

  srsw_cmd_t cmd;
  srsw_sts_t sts;

  srsw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  srsw_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .req_opcode_i       (req_i.opcode),
    .req_ack_seq_i      (req_i.ack_seq),
    .req_final_packet_i (req_i.final_packet),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .rsp_o              (rsp_o)
  );

endmodule
`default_nettype wire

// ===== rtl/srsw_ctrl.sv =====
// Controller: request acceptance and retransmission scan sequencing.
`timescale 1ns / 1ps
`default_nettype none
module srsw_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  output logic                     req_ready_o,
  input  wire srsw_pkg::srsw_sts_t sts_i,
  output srsw_pkg::srsw_cmd_t      cmd_o
);
  import srsw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = sts_i.out_free;
        cmd_o.exec  = req_valid_i && sts_i.out_free;
        if (cmd_o.exec && sts_i.scan_start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.retx = sts_i.out_free;
        if (cmd_o.retx && sts_i.scan_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/srsw_dp.sv =====
// Datapath: window state, idle timer, retransmission mask and result register.
`timescale 1ns / 1ps
`default_nettype none
module srsw_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [srsw_pkg::TickW-1:0] cfg_data_i,
  input  wire logic [1:0]                req_opcode_i,
  input  wire logic [srsw_pkg::SeqW-1:0] req_ack_seq_i,
  input  wire logic                      req_final_packet_i,
  input  wire srsw_pkg::srsw_cmd_t       cmd_i,
  output srsw_pkg::srsw_sts_t            sts_o,
  srsw_out_if.source                     rsp_o
);
  import srsw_pkg::*;

  logic [WindowSlots-1:0] bitmap_q, bitmap_d;
  logic [WindowSlots-1:0] pend_q, pend_d;
  logic [SeqW-1:0]        base_q, base_d;
  logic [SeqW-1:0]        next_q, next_d;
  logic                   more_q, more_d;
  logic [TickW-1:0]       idle_q, idle_d;
  logic [TickW-1:0]       timeout_q;

  logic                   out_valid_q, out_valid_d;
  kind_e                  kind_q, kind_d;
  logic [SeqW-1:0]        seq_q, seq_d;
  logic                   last_q, last_d;
  logic                   relay_q, relay_d;
  logic [SeqW-1:0]        wbase_q, wbase_d;
  logic                   done_q, done_d;
  logic                   run_end_q, run_end_d;

  logic [SeqW-1:0]        infl_w;
  logic [CntW-1:0]        infl;
  logic [WindowSlots-1:0] infl_mask;
  logic [WindowSlots-1:0] pend_init;
  logic [SeqW-1:0]        ack_off;
  logic [WindowSlots-1:0] bm_ack;
  logic [CntW-1:0]        slide;
  logic                   run;
  logic [TickW-1:0]       idle_inc;
  logic                   timeout_hit;
  logic                   room;
  logic [SlotIdxW-1:0]    scan_idx;
  logic [SeqW-1:0]        retx_seq;
  logic                   load;

  assign infl_w = next_q - base_q;
  assign infl   = infl_w[CntW-1:0];
  assign room   = more_q && (infl < CntW'(WindowSlots));

  always_comb begin
    for (int i = 0; i < WindowSlots; i++) begin
      infl_mask[i] = CntW'(i) < infl;
    end
  end

  assign pend_init = ~bitmap_q & infl_mask;

  // mark the acked slot, then count leading acked slots
  assign ack_off = req_ack_seq_i - base_q;
  always_comb begin
    bm_ack = bitmap_q;
    if (ack_off < SeqW'(infl)) begin
      bm_ack[ack_off[SlotIdxW-1:0]] = 1'b1;
    end
  end

  always_comb begin
    run   = 1'b1;
    slide = '0;
    for (int i = 0; i < WindowSlots; i++) begin
      run   = run & bm_ack[i];
      slide = slide + CntW'(run);
    end
  end

  assign idle_inc    = (idle_q == IdleMax) ? idle_q : idle_q + TickW'(1);
  assign timeout_hit = idle_inc >= timeout_q;

  // oldest pending slot
  always_comb begin
    scan_idx = '0;
    for (int i = WindowSlots - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        scan_idx = SlotIdxW'(i);
      end
    end
  end

  assign retx_seq = base_q + SeqW'(scan_idx);

  assign sts_o.out_free   = !out_valid_q || rsp_o.ready;
  assign sts_o.scan_start = (opcode_e'(req_opcode_i) == OP_TICK) && timeout_hit &&
                            (pend_init != '0);
  assign sts_o.scan_last  = (pend_q & (pend_q - WindowSlots'(1))) == '0;

  always_comb begin
    bitmap_d  = bitmap_q;
    pend_d    = pend_q;
    base_d    = base_q;
    next_d    = next_q;
    more_d    = more_q;
    idle_d    = idle_q;
    kind_d    = kind_q;
    seq_d     = seq_q;
    last_d    = last_q;
    relay_d   = relay_q;
    run_end_d = run_end_q;
    load      = 1'b0;

    if (cmd_i.exec) begin
      kind_d    = KIND_STATUS;
      seq_d     = '0;
      last_d    = 1'b0;
      relay_d   = 1'b0;
      run_end_d = 1'b1;
      load      = !sts_o.scan_start;
      unique case (opcode_e'(req_opcode_i))
        OP_ACK: begin
          bitmap_d = bm_ack >> slide;
          base_d   = base_q + SeqW'(slide);
        end
        OP_SEND: begin
          if (room) begin
            next_d  = next_q + SeqW'(1);
            more_d  = more_q && !req_final_packet_i;
            idle_d  = '0;
            kind_d  = KIND_NEW;
            seq_d   = next_q;
            last_d  = req_final_packet_i;
            relay_d = next_q[0];
          end else begin
            kind_d = KIND_REFUSED;
          end
        end
        OP_TICK: begin
          idle_d = idle_inc;
          if (sts_o.scan_start) begin
            idle_d = '0;
            pend_d = pend_init;
          end
        end
        OP_RSVD: begin
        end
        default: begin
        end
      endcase
    end else if (cmd_i.retx) begin
      load      = 1'b1;
      pend_d    = pend_q & (pend_q - WindowSlots'(1));
      kind_d    = KIND_RETX;
      seq_d     = retx_seq;
      last_d    = !more_q && (retx_seq == next_q - SeqW'(1));
      relay_d   = retx_seq[0];
      run_end_d = sts_o.scan_last;
    end

    wbase_d     = load ? base_d : wbase_q;
    done_d      = load ? (!more_d && (next_d == base_d)) : done_q;
    out_valid_d = load ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_q    <= '0;
      pend_q      <= '0;
      base_q      <= '0;
      next_q      <= '0;
      more_q      <= 1'b1;
      idle_q      <= '0;
      timeout_q   <= TimeoutReset;
      out_valid_q <= 1'b0;
    end else begin
      bitmap_q    <= bitmap_d;
      pend_q      <= pend_d;
      base_q      <= base_d;
      next_q      <= next_d;
      more_q      <= more_d;
      idle_q      <= idle_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    seq_q     <= seq_d;
    last_q    <= last_d;
    relay_q   <= relay_d;
    wbase_q   <= wbase_d;
    done_q    <= done_d;
    run_end_q <= run_end_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.kind           = kind_q;
  assign rsp_o.seq_out        = seq_q;
  assign rsp_o.packet_is_last = last_q;
  assign rsp_o.relay_select   = relay_q;
  assign rsp_o.window_base    = wbase_q;
  assign rsp_o.transfer_done  = done_q;
  assign rsp_o.run_end        = run_end_q;

  a_infl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    infl_w <= SeqW'(WindowSlots))
    else $error("in-flight count exceeds window");

  a_bitmap_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((bitmap_q & ~infl_mask) == '0) && !bitmap_q[0])
    else $error("ack bitmap holds bits outside the unslid window");

  a_retx_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == KIND_RETX) |-> ((seq_q - base_q) < SeqW'(infl)))
    else $error("retransmitted sequence outside window");

endmodule
`default_nettype wire
